@@ sv/kms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, register map and key code table of the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

	localparam int unsigned NumRows   = 4;
	localparam int unsigned NumCols   = 4;
	localparam int unsigned CfgAddrW  = 3;
	localparam int unsigned CfgDataW  = 32;
	localparam int unsigned TickW     = 16;

	localparam logic [15:0] SettleReset = 16'd50;
	localparam logic [15:0] GapReset    = 16'd0;

	// register index, taken from the word address bit
	typedef enum logic {
		REG_SETTLE = 1'b0,
		REG_GAP    = 1'b1
	} reg_idx_t;

	// item kind carried on the input tuser
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// configuration seen by the scanner
	typedef struct packed {
		logic [TickW-1:0] settle_ticks;
		logic [TickW-1:0] scan_gap_ticks;
	} cfg_t;

	// row-major key index to ASCII
	function automatic logic [7:0] key_ascii(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = "1";
			4'd1:    ch = "2";
			4'd2:    ch = "3";
			4'd3:    ch = "A";
			4'd4:    ch = "4";
			4'd5:    ch = "5";
			4'd6:    ch = "6";
			4'd7:    ch = "B";
			4'd8:    ch = "7";
			4'd9:    ch = "8";
			4'd10:   ch = "9";
			4'd11:   ch = "C";
			4'd12:   ch = "*";
			4'd13:   ch = "0";
			4'd14:   ch = "#";
			default: ch = "D";
		endcase
		return ch;
	endfunction

endpackage : kms_pkg
`default_nettype wire

@@ sv/kms_apb_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_apb_regs
// APB register file holding the settle and scan gap tick counts.
// ----------------------------------------------------------------------------
module kms_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kms_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [kms_pkg::CfgDataW-1:0]  pwdata,
	output logic      [kms_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready,
	output kms_pkg::cfg_t                      cfg
);
	import kms_pkg::*;

	logic [TickW-1:0] settle_q;
	logic [TickW-1:0] gap_q;
	logic             wr_en;
	reg_idx_t         sel;

	assign pready = 1'b1;
	assign sel    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SettleReset;
			gap_q    <= GapReset;
		end else if (wr_en) begin
			unique case (sel)
				REG_SETTLE: settle_q <= pwdata[TickW-1:0];
				REG_GAP:    gap_q    <= pwdata[TickW-1:0];
				default:    settle_q <= settle_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (sel)
			REG_SETTLE: prdata = {{(CfgDataW-TickW){1'b0}}, settle_q};
			REG_GAP:    prdata = {{(CfgDataW-TickW){1'b0}}, gap_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.settle_ticks   = settle_q;
	assign cfg.scan_gap_ticks = gap_q;

endmodule : kms_apb_regs
`default_nettype wire

@@ sv/keypad_matrix_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted item's result is registered into the output register in the next cycle.
// Throughput: one item per cycle; the scan state updates in the accepting cycle.
// The output register frees as its transaction completes, so input stalls only
// while a result waits and the downstream side holds tready low.
// Reset (arst_n low): snapshots and key buffer clear, row 0 in its settle phase,
// settle_ticks = 50, scan_gap_ticks = 0.
// ----------------------------------------------------------------------------
// keypad_matrix_scanner
// 4x4 key matrix scanner with stability check and a one-key buffer.
// ----------------------------------------------------------------------------
module keypad_matrix_scanner (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [3:0] column_levels
	input  wire logic [0:0]                    s_axis_tuser,  // [0] operation
	// output stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [15:0]                   m_axis_tdata,  // [3:0] row_drive, [11:4] key_char
	output logic      [0:0]                    m_axis_tuser,  // [0] key_valid
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kms_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [kms_pkg::CfgDataW-1:0]  pwdata,
	output logic      [kms_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready
);
	import kms_pkg::*;

	typedef enum logic {
		PH_SETTLE = 1'b0,
		PH_GAP    = 1'b1
	} phase_t;

	cfg_t cfg;

	kms_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// scan state
	logic [NumCols-1:0] cur_q  [NumRows];
	logic [NumCols-1:0] prev_q [NumRows];
	logic [NumCols-1:0] stab_q [NumRows];
	logic               full_q;
	logic [3:0]         key_idx_q;
	logic [1:0]         row_q;
	phase_t             phase_q;
	logic [TickW-1:0]   wait_q;

	// next state
	logic [NumCols-1:0] cur_d  [NumRows];
	logic [NumCols-1:0] prev_d [NumRows];
	logic [NumCols-1:0] stab_d [NumRows];
	logic               full_d;
	logic [3:0]         key_idx_d;
	logic [1:0]         row_d;
	phase_t             phase_d;
	logic [TickW-1:0]   wait_d;

	// result
	logic [3:0]         row_drive;
	logic               key_valid;
	logic [7:0]         key_char;

	logic               accept;
	op_t                op;
	logic [NumCols-1:0] cols;
	logic [TickW:0]     gap_next;
	logic [NumCols-1:0] rising;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser[0]);
	assign cols          = s_axis_tdata[3:0];
	assign gap_next      = {1'b0, wait_q} + {{TickW{1'b0}}, 1'b1};

	// row levels held during this item
	always_comb begin
		if (phase_q == PH_SETTLE) begin
			row_drive = ~(4'b0001 << row_q);
		end else begin
			row_drive = 4'hF;
		end
	end

	// item processing: tick advances the scan, read drains the buffer
	always_comb begin
		cur_d     = cur_q;
		prev_d    = prev_q;
		stab_d    = stab_q;
		full_d    = full_q;
		key_idx_d = key_idx_q;
		row_d     = row_q;
		phase_d   = phase_q;
		wait_d    = wait_q;
		key_valid = 1'b0;
		key_char  = 8'd0;
		rising    = '0;
		if (op == OP_READ) begin
			if (full_q) begin
				key_valid = 1'b1;
				key_char  = key_ascii(key_idx_q);
			end
			full_d = 1'b0;
		end else if (phase_q == PH_SETTLE) begin
			if (wait_q < cfg.settle_ticks) begin
				wait_d = wait_q + 1'b1;
			end else begin
				wait_d        = '0;
				cur_d[row_q]  = ~cols;
				if (row_q != 2'd3) begin
					row_d = row_q + 1'b1;
				end else begin
					// end of scan: compare each row with the previous scan
					for (int r = 0; r < NumRows; r++) begin
						if (cur_d[r] == prev_q[r]) begin
							rising    = cur_d[r] & ~stab_q[r];
							stab_d[r] = cur_d[r];
							for (int c = 0; c < NumCols; c++) begin
								if (rising[c] && !full_d) begin
									key_idx_d = 4'(r * NumCols + c);
									full_d    = 1'b1;
								end
							end
						end
						prev_d[r] = cur_d[r];
					end
					row_d   = 2'd0;
					phase_d = (cfg.scan_gap_ticks == '0) ? PH_SETTLE : PH_GAP;
				end
			end
		end else begin
			if (gap_next >= {1'b0, cfg.scan_gap_ticks}) begin
				wait_d  = '0;
				row_d   = 2'd0;
				phase_d = PH_SETTLE;
			end else begin
				wait_d = gap_next[TickW-1:0];
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NumRows; r++) begin
				cur_q[r]  <= '0;
				prev_q[r] <= '0;
				stab_q[r] <= '0;
			end
			full_q    <= 1'b0;
			key_idx_q <= '0;
			row_q     <= '0;
			phase_q   <= PH_SETTLE;
			wait_q    <= '0;
		end else if (accept) begin
			cur_q     <= cur_d;
			prev_q    <= prev_d;
			stab_q    <= stab_d;
			full_q    <= full_d;
			key_idx_q <= key_idx_d;
			row_q     <= row_d;
			phase_q   <= phase_d;
			wait_q    <= wait_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_axis_tdata <= {4'd0, key_char, row_drive};
			m_axis_tuser <= key_valid;
		end
	end

endmodule : keypad_matrix_scanner
`default_nettype wire
